@@ rtl/tx_queue_jitter_scheduler_core_defines.svh @@
// Assertion macros shared by the scheduler checker.
`ifndef TX_QUEUE_JITTER_SCHEDULER_CORE_DEFINES_SVH
`define TX_QUEUE_JITTER_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TXQJS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TXQJS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

@@ rtl/txqjs_pkg.sv @@
// Shared types and constants of the transmit queue jitter scheduler.
package txqjs_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 8;

  // Operation codes
  localparam logic [1:0] OP_ENQUEUE    = 2'd0;
  localparam logic [1:0] OP_INVALIDATE = 2'd1;
  localparam logic [1:0] OP_TICK       = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH = 2'd2;

  // Field widths
  localparam int HANDLE_W = 16;
  localparam int LENGTH_W = 8;
  localparam int TIME_W   = 32;
  localparam int JITTER_W = 16;

  // One queued packet
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [LENGTH_W-1:0] length;
    logic                hello;
  } entry_t;

endpackage

@@ rtl/tx_queue_jitter_scheduler_core.sv @@
// Transmit queue scheduler: ring FIFO in a memory, jitter backoff, serial modulo.
//
// Input channel (in_valid/in_ready) takes one request: enqueue, invalidate a
// queued hello, or a time tick. Every request yields exactly one result on the
// output channel (out_valid/out_ready), in order.
// Config port: cfg_wr_en/cfg_index/cfg_wdata writes jitter_ms, radio_present,
// refresh_enabled; write only while no request is in flight.
// Enqueue, invalidate and ticks that need no arming go from accept through S_EXEC
// to the output register. A tick that arms the backoff first runs the 32-step
// restoring modulo unit (one quotient bit per cycle), then an add step in S_ARM.
// One request is worked at a time; in_ready rises again once the result sits
// in the output register, so the next request overlaps a waiting result.
// Queue entries live in a single-port-write, registered-read memory read at the
// head; entries are not cleared at reset (only written slots are read).
// Reset: empty queue, backoff disarmed, jitter 0, radio present, refresh off.
// A stalled receiver holds the result; the block then stops before the
// commit of the following request until the output register frees.
module tx_queue_jitter_scheduler_core #(
  parameter int QUEUE_DEPTH = txqjs_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [txqjs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [txqjs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_operation,
  input  logic [txqjs_pkg::HANDLE_W-1:0]   in_packet_handle,
  input  logic [txqjs_pkg::LENGTH_W-1:0]   in_packet_length,
  input  logic                             in_is_hello,
  input  logic [txqjs_pkg::TIME_W-1:0]     in_now_ms,
  input  logic [txqjs_pkg::TIME_W-1:0]     in_random_word,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_accepted,
  output logic                             out_dequeued,
  output logic                             out_tx_valid,
  output logic [txqjs_pkg::HANDLE_W-1:0]   out_tx_packet_handle,
  output logic                             out_tx_refresh_hello,
  output logic                             out_hello_attempted
);
  import txqjs_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int DIV_W = JITTER_W + 1;
  localparam int STEP_W = $clog2(TIME_W);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_ARM  = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  // control state
  logic [1:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    hcount_r, hcount_nxt;
  logic                armed_r, armed_nxt;
  logic                stale_r, stale_nxt;
  logic [TIME_W-1:0]   nst_r, nst_nxt;
  logic [JITTER_W-1:0] jitter_r;
  logic                radio_r;
  logic                refresh_r;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;

  // request payload and divider datapath
  logic [1:0]          op_r, op_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic [LENGTH_W-1:0] len_r, len_nxt;
  logic                hello_r, hello_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [TIME_W-1:0]   quo_r, quo_nxt;
  logic [DIV_W-1:0]    rem_r, rem_nxt;

  // result payload
  logic                acc_r, acc_nxt;
  logic                deq_r, deq_nxt;
  logic                txv_r, txv_nxt;
  logic [HANDLE_W-1:0] txh_r, txh_nxt;
  logic                ref_r, ref_nxt;
  logic                hatt_r, hatt_nxt;

  // entry memory
  entry_t              mem [QUEUE_DEPTH];
  entry_t              rd_data_r;
  entry_t              wr_data;
  logic                wr_en;
  logic [IDX_W-1:0]    tail;
  logic [SUM_W-1:0]    tail_sum;

  // misc combinational
  logic                accept;
  logic                commit;
  logic                full;
  logic                pop;
  logic                refresh;
  logic [TIME_W-1:0]   diff;
  logic [DIV_W:0]      trial;
  logic [DIV_W:0]      divisor;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));

  // tail slot, wrapped at the queue depth
  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
                                                  : IDX_W'(tail_sum);

  // due check: wrapped signed difference not negative
  assign diff    = now_r - nst_r;
  assign pop     = (op_r == OP_TICK) && (count_r != '0) && !diff[TIME_W-1];
  assign refresh = rd_data_r.hello && stale_r && refresh_r;

  // one restoring step of random mod (jitter + 1)
  assign divisor = {1'b0, DIV_W'(jitter_r) + DIV_W'(1)};
  assign trial   = {rem_r, quo_r[TIME_W-1]};

  assign wr_en   = commit && (op_r == OP_ENQUEUE) && !full;
  assign wr_data = '{handle: handle_r, length: len_r, hello: hello_r};

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    hcount_nxt    = hcount_r;
    armed_nxt     = armed_r;
    stale_nxt     = stale_r;
    nst_nxt       = nst_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    op_nxt        = op_r;
    handle_nxt    = handle_r;
    len_nxt       = len_r;
    hello_nxt     = hello_r;
    now_nxt       = now_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    deq_nxt       = deq_r;
    txv_nxt       = txv_r;
    txh_nxt       = txh_r;
    ref_nxt       = ref_r;
    hatt_nxt      = hatt_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_operation;
          handle_nxt = in_packet_handle;
          len_nxt    = in_packet_length;
          hello_nxt  = in_is_hello;
          now_nxt    = in_now_ms;
          quo_nxt    = in_random_word;
          rem_nxt    = '0;
          step_nxt   = '0;
          if ((in_operation == OP_TICK) && (count_r != '0) && !armed_r) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end

      S_DIV: begin
        if (trial >= divisor) begin
          rem_nxt = DIV_W'(trial - divisor);
        end else begin
          rem_nxt = DIV_W'(trial);
        end
        quo_nxt  = {quo_r[TIME_W-2:0], 1'b0};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(TIME_W - 1)) begin
          state_nxt = S_ARM;
        end
      end

      S_ARM: begin
        nst_nxt   = now_r + TIME_W'(rem_r);
        armed_nxt = 1'b1;
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          acc_nxt  = 1'b0;
          deq_nxt  = 1'b0;
          txv_nxt  = 1'b0;
          txh_nxt  = '0;
          ref_nxt  = 1'b0;
          hatt_nxt = 1'b0;
          case (op_r)
            OP_ENQUEUE: begin
              if (!full) begin
                acc_nxt   = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                if (hello_r) begin
                  hcount_nxt = hcount_r + CNT_W'(1);
                end
              end
            end
            OP_INVALIDATE: begin
              if (hcount_r != '0) begin
                stale_nxt = 1'b1;
              end
            end
            OP_TICK: begin
              if (pop) begin
                deq_nxt   = 1'b1;
                txh_nxt   = rd_data_r.handle;
                ref_nxt   = refresh;
                txv_nxt   = radio_r && (refresh || (rd_data_r.length != '0));
                armed_nxt = 1'b0;
                count_nxt = count_r - CNT_W'(1);
                head_nxt  = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : head_r + IDX_W'(1);
                if (rd_data_r.hello) begin
                  hatt_nxt  = 1'b1;
                  stale_nxt = 1'b0;
                  if (hcount_r != '0) begin
                    hcount_nxt = hcount_r - CNT_W'(1);
                  end
                end
              end
            end
            default: begin
            end
          endcase
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      hcount_r    <= '0;
      armed_r     <= 1'b0;
      stale_r     <= 1'b0;
      nst_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      hcount_r    <= hcount_nxt;
      armed_r     <= armed_nxt;
      stale_r     <= stale_nxt;
      nst_r       <= nst_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jitter_r  <= '0;
      radio_r   <= 1'b1;
      refresh_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_JITTER:  jitter_r  <= cfg_wdata;
        REG_RADIO:   radio_r   <= cfg_wdata[0];
        REG_REFRESH: refresh_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    handle_r <= handle_nxt;
    len_r    <= len_nxt;
    hello_r  <= hello_nxt;
    now_r    <= now_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    acc_r    <= acc_nxt;
    deq_r    <= deq_nxt;
    txv_r    <= txv_nxt;
    txh_r    <= txh_nxt;
    ref_r    <= ref_nxt;
    hatt_r   <= hatt_nxt;
  end

  // entry memory: write at tail on enqueue, registered read at head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= wr_data;
    end
    rd_data_r <= mem[head_r];
  end

  assign out_valid            = out_valid_r;
  assign out_accepted         = acc_r;
  assign out_dequeued         = deq_r;
  assign out_tx_valid         = txv_r;
  assign out_tx_packet_handle = txh_r;
  assign out_tx_refresh_hello = ref_r;
  assign out_hello_attempted  = hatt_r;

endmodule

@@ rtl/txqjs_checker.sv @@
// Port-level checks for the scheduler, bound to the top level.
`include "tx_queue_jitter_scheduler_core_defines.svh"

module txqjs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_accepted,
  input logic                             out_dequeued,
  input logic                             out_tx_valid,
  input logic [txqjs_pkg::HANDLE_W-1:0]   out_tx_packet_handle,
  input logic                             out_tx_refresh_hello,
  input logic                             out_hello_attempted
);

  // a stalled result stays put
  `TXQJS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_tx_packet_handle) && $stable(out_dequeued))

  // one request in flight: ready drops right after an accept
  `TXQJS_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // an enqueue result never also reports a pop
  `TXQJS_ASSERT_NOW(a_acc_excl, out_valid, !(out_accepted && out_dequeued))

  // transmit, refresh and hello flags only come with a pop
  `TXQJS_ASSERT_NOW(a_pop_flags,
    out_valid && (out_tx_valid || out_tx_refresh_hello || out_hello_attempted),
    out_dequeued)

  // handle is zero unless an entry left the queue
  `TXQJS_ASSERT_NOW(a_handle_zero, out_valid && !out_dequeued,
    out_tx_packet_handle == '0)

endmodule

bind tx_queue_jitter_scheduler_core txqjs_checker u_txqjs_checker (.*);
